>>> rtl/core/indent_dedent_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// indent_dedent_tokenizer_macros.svh
// Assertion shorthands shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef INDENT_DEDENT_TOKENIZER_MACROS_SVH
`define INDENT_DEDENT_TOKENIZER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define IDT_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define IDT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/idt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types and constants of the indent/dedent tokenizer.
// ----------------------------------------------------------------------------
package idt_pkg;

   // default sizes
   localparam int STACK_DEPTH_DEF = 32;
   localparam int WIDTH_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // tokens per input word
   localparam int MAX_RESULTS = 32;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // port field widths
   localparam int CHAR_W     = 8;
   localparam int LEVEL_W    = 16;
   localparam int TAB_W      = 7;
   localparam int CMD_KIND_W = 2;

   typedef logic [LEVEL_W-1:0] level_type;

   // register reset values
   localparam logic [TAB_W-1:0] TAB_WIDTH_RST = 7'd8;
   localparam logic             SKIP_CMT_RST  = 1'b1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_TAB_WIDTH   = 1'b0,
      CSR_SKIP_COMMENT = 1'b1
   } csr_type;

   // result token kinds
   typedef enum logic [1:0] {
      TOK_INDENT   = 2'd0,
      TOK_DEDENT   = 2'd1,
      TOK_OVERFLOW = 2'd2
   } tok_type;

   // commands from front end to back end, one per input word
   typedef enum logic [CMD_KIND_W-1:0] {
      CMD_NOP        = 2'd0,
      CMD_DECIDE     = 2'd1,
      CMD_EOI        = 2'd2,
      CMD_EOI_DECIDE = 2'd3
   } cmd_kind_type;

   // line scanner states
   typedef enum logic [1:0] {
      LN_START = 2'd0,
      LN_SLASH = 2'd1,
      LN_BODY  = 2'd2
   } ln_state_type;

   // level engine states
   typedef enum logic [3:0] {
      BK_IDLE     = 4'd0,
      BK_CMD      = 4'd1,
      BK_TOP_RD   = 4'd2,
      BK_TOP_CHK  = 4'd3,
      BK_POP_RD   = 4'd4,
      BK_POP_CHK  = 4'd5,
      BK_DRN_RD   = 4'd6,
      BK_DRN_EMIT = 4'd7,
      BK_FLUSH    = 4'd8
   } bk_state_type;

endpackage

>>> rtl/core/idt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module idt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/idt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_queue
// Short command FIFO between the line scanner and the level engine.
// ----------------------------------------------------------------------------
`include "indent_dedent_tokenizer_macros.svh"

module idt_queue #(
   parameter int DATA_W = 18,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill level stays within the slots
   `IDT_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= FULL_CNT, "queue count overrun")

endmodule

>>> rtl/core/idt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_front
// Line scanner: measures leading whitespace and turns each input word
// into one command for the level engine.
// ----------------------------------------------------------------------------
`include "indent_dedent_tokenizer_macros.svh"

module idt_front #(
   parameter int WIDTH_BITS = idt_pkg::WIDTH_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // input stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [idt_pkg::CHAR_W-1:0]                req_tdata,   // [7:0] char_code
   input  logic                                      req_tlast,   // end_of_input
   // configuration writes
   input  logic                                      csr_we,
   input  logic [0:0]                                csr_index,
   input  logic [idt_pkg::TAB_W-1:0]                 csr_wdata,
   // command queue
   input  logic                                      q_ready,
   output logic                                      q_push,
   output logic [idt_pkg::CMD_KIND_W+WIDTH_BITS-1:0] q_data
);

   localparam int SUM_W = WIDTH_BITS + 1;

   idt_pkg::ln_state_type        state_ff, state_in;
   logic [idt_pkg::TAB_W-1:0]    tab_width_ff;
   logic                         skip_cmt_ff;
   logic [WIDTH_BITS-1:0]        lead_ff, lead_in;
   logic                         accept;
   logic                         is_ws, is_eol, is_slash, is_space;
   logic [SUM_W-1:0]             lead_sum;
   idt_pkg::cmd_kind_type        cmd_kind;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   // character classes
   assign is_space = (req_tdata == idt_pkg::CH_SPACE);
   assign is_ws    = is_space || (req_tdata == idt_pkg::CH_TAB);
   assign is_eol   = (req_tdata == idt_pkg::CH_LF) || (req_tdata == idt_pkg::CH_CR);
   assign is_slash = (req_tdata == idt_pkg::CH_SLASH);

   // saturating width add
   assign lead_sum = {1'b0, lead_ff}
                   + (is_space ? SUM_W'(1) : SUM_W'(tab_width_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (req_tlast) begin
            state_in = idt_pkg::LN_START;
         end else begin
            unique case (state_ff)
               idt_pkg::LN_START: begin
                  priority if (is_eol || is_ws) begin
                     state_in = idt_pkg::LN_START;
                  end else if (is_slash && skip_cmt_ff) begin
                     state_in = idt_pkg::LN_SLASH;
                  end else begin
                     state_in = idt_pkg::LN_BODY;
                  end
               end
               idt_pkg::LN_SLASH: begin
                  state_in = (is_eol && !is_slash) ? idt_pkg::LN_START : idt_pkg::LN_BODY;
               end
               idt_pkg::LN_BODY: begin
                  if (is_eol) begin
                     state_in = idt_pkg::LN_START;
                  end
               end
               default: state_in = idt_pkg::LN_START;
            endcase
         end
      end
   end

   // command for the level engine
   always_comb begin
      cmd_kind = idt_pkg::CMD_NOP;
      if (req_tlast) begin
         cmd_kind = (state_ff == idt_pkg::LN_SLASH) ? idt_pkg::CMD_EOI_DECIDE
                                                    : idt_pkg::CMD_EOI;
      end else begin
         unique case (state_ff)
            idt_pkg::LN_START: begin
               if (!is_ws && !is_eol && !(is_slash && skip_cmt_ff)) begin
                  cmd_kind = idt_pkg::CMD_DECIDE;
               end
            end
            idt_pkg::LN_SLASH: begin
               if (!is_slash) begin
                  cmd_kind = idt_pkg::CMD_DECIDE;
               end
            end
            idt_pkg::LN_BODY: cmd_kind = idt_pkg::CMD_NOP;
            default:          cmd_kind = idt_pkg::CMD_NOP;
         endcase
      end
   end

   assign q_push = accept;
   assign q_data = {cmd_kind, lead_ff};

   // leading width
   always_comb begin
      lead_in = lead_ff;
      if (accept) begin
         if (req_tlast || is_eol) begin
            lead_in = '0;
         end else if (state_ff == idt_pkg::LN_START && is_ws) begin
            lead_in = lead_sum[WIDTH_BITS] ? '1 : lead_sum[WIDTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idt_pkg::LN_START;
         lead_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lead_ff  <= lead_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= idt_pkg::TAB_WIDTH_RST;
         skip_cmt_ff  <= idt_pkg::SKIP_CMT_RST;
      end else if (csr_we) begin
         unique case (idt_pkg::csr_type'(csr_index))
            idt_pkg::CSR_TAB_WIDTH:    tab_width_ff <= csr_wdata;
            idt_pkg::CSR_SKIP_COMMENT: skip_cmt_ff  <= csr_wdata[0];
            default:                   tab_width_ff <= tab_width_ff;
         endcase
      end
   end

   // end of input always returns the scanner to a clean line start
   `IDT_ASSERT_NEXT(a_eoi_clears_line, clock, reset, accept && req_tlast, (state_ff == idt_pkg::LN_START) && (lead_ff == '0), "line state not cleared after end of input")

endmodule

>>> rtl/core/idt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_back
// Level engine: keeps the stack of open indent levels in RAM, decides
// indent / dedent per line and streams the tokens out.
// ----------------------------------------------------------------------------
`include "indent_dedent_tokenizer_macros.svh"

module idt_back #(
   parameter int STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF,
   parameter int WIDTH_BITS  = idt_pkg::WIDTH_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // command queue
   input  logic                                      q_valid,
   input  logic [idt_pkg::CMD_KIND_W+WIDTH_BITS-1:0] q_data,
   output logic                                      q_pop,
   // token stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [idt_pkg::LEVEL_W-1:0]               rsp_tdata,   // [15:0] level_width
   output logic [1:0]                                rsp_tuser,   // [1:0] token_kind
   output logic                                      rsp_tlast    // last
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int USED_W = FILL_W + 1;
   localparam int CNT_W  = idt_pkg::RES_CNT_W;
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(STACK_DEPTH);
   localparam logic [USED_W-1:0] USED_MAX  = USED_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(idt_pkg::MAX_RESULTS);

   idt_pkg::bk_state_type state_ff, state_in;
   idt_pkg::cmd_kind_type cmd_kind_ff, cmd_kind_in, q_kind;
   logic [WIDTH_BITS-1:0] cmd_w_ff, cmd_w_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     pend_ff, pend_in;
   logic                  post_ff, post_in;
   logic [CNT_W-1:0]      res_cnt_ff, res_cnt_in;

   // one-token staging so the final token of a word can carry tlast
   logic                  hold_valid_ff, hold_valid_in;
   idt_pkg::tok_type      hold_kind_ff, hold_kind_in;
   idt_pkg::level_type    hold_w_ff, hold_w_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   idt_pkg::tok_type      rsp_kind_ff, rsp_kind_in;
   idt_pkg::level_type    rsp_w_ff, rsp_w_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ram
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [WIDTH_BITS-1:0] rd_data;

   // control strobes and status
   logic [FILL_W-1:0]     fill_m1, drain_idx;
   logic [USED_W-1:0]     used;
   logic [WIDTH_BITS-1:0] top_val;
   logic                  w_gt_top, w_lt_top, full, cap_hit, out_free;
   logic                  gen_req, gen_ok, gen_fire, flush_fire, load_out;
   logic                  drain_done, pop_more, decide_end;
   idt_pkg::tok_type      gen_kind;
   idt_pkg::level_type    gen_w;
   idt_pkg::bk_state_type after_decide;

   assign q_kind = idt_pkg::cmd_kind_type'(q_data[idt_pkg::CMD_KIND_W+WIDTH_BITS-1 -: idt_pkg::CMD_KIND_W]);

   // status
   assign fill_m1    = fill_ff - FILL_W'(1);
   assign drain_idx  = fill_ff + pend_ff - FILL_W'(1);
   assign used       = {1'b0, fill_ff} + {1'b0, pend_ff};
   assign top_val    = (fill_ff == '0) ? '0 : rd_data;
   assign w_gt_top   = (cmd_w_ff > top_val);
   assign w_lt_top   = (cmd_w_ff < top_val);
   assign full       = (fill_ff == FULL_FILL);
   assign cap_hit    = (res_cnt_ff == CNT_MAX);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign gen_ok     = cap_hit || !hold_valid_ff || out_free;
   assign drain_done = (pend_ff == '0) || cap_hit;
   assign pop_more   = (rd_data > cmd_w_ff);
   assign after_decide = (cmd_kind_ff == idt_pkg::CMD_EOI_DECIDE) ? idt_pkg::BK_CMD
                                                                 : idt_pkg::BK_DRN_RD;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idt_pkg::BK_IDLE: begin
            if (q_valid) begin
               priority if (pend_ff != '0) begin
                  state_in = idt_pkg::BK_DRN_RD;
               end else if (q_kind == idt_pkg::CMD_NOP) begin
                  state_in = idt_pkg::BK_IDLE;
               end else begin
                  state_in = idt_pkg::BK_CMD;
               end
            end
         end
         idt_pkg::BK_CMD: begin
            unique case (cmd_kind_ff)
               idt_pkg::CMD_NOP:        state_in = idt_pkg::BK_FLUSH;
               idt_pkg::CMD_EOI:        state_in = idt_pkg::BK_DRN_RD;
               idt_pkg::CMD_DECIDE,
               idt_pkg::CMD_EOI_DECIDE: state_in = idt_pkg::BK_TOP_RD;
               default:                 state_in = idt_pkg::BK_FLUSH;
            endcase
         end
         idt_pkg::BK_TOP_RD:  state_in = idt_pkg::BK_TOP_CHK;
         idt_pkg::BK_TOP_CHK: begin
            priority if (w_gt_top) begin
               if (gen_ok) begin
                  state_in = after_decide;
               end
            end else if (w_lt_top) begin
               state_in = idt_pkg::BK_POP_RD;
            end else begin
               state_in = after_decide;
            end
         end
         idt_pkg::BK_POP_RD: begin
            state_in = (fill_ff == '0) ? after_decide : idt_pkg::BK_POP_CHK;
         end
         idt_pkg::BK_POP_CHK: begin
            state_in = pop_more ? idt_pkg::BK_POP_RD : after_decide;
         end
         idt_pkg::BK_DRN_RD: begin
            if (drain_done) begin
               state_in = post_ff ? idt_pkg::BK_FLUSH : idt_pkg::BK_CMD;
            end else begin
               state_in = idt_pkg::BK_DRN_EMIT;
            end
         end
         idt_pkg::BK_DRN_EMIT: begin
            if (gen_ok) begin
               state_in = idt_pkg::BK_DRN_RD;
            end
         end
         idt_pkg::BK_FLUSH: begin
            if (!hold_valid_ff || out_free) begin
               state_in = idt_pkg::BK_IDLE;
            end
         end
         default: state_in = idt_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop      = 1'b0;
      gen_req    = 1'b0;
      gen_kind   = idt_pkg::TOK_DEDENT;
      gen_w      = idt_pkg::level_type'(rd_data);
      flush_fire = 1'b0;
      decide_end = 1'b0;
      rd_addr    = fill_m1[ADDR_W-1:0];
      unique case (state_ff)
         idt_pkg::BK_IDLE: q_pop = q_valid;
         idt_pkg::BK_TOP_CHK: begin
            gen_req    = w_gt_top;
            gen_kind   = full ? idt_pkg::TOK_OVERFLOW : idt_pkg::TOK_INDENT;
            gen_w      = idt_pkg::level_type'(cmd_w_ff);
            decide_end = w_gt_top ? gen_ok : !w_lt_top;
         end
         idt_pkg::BK_POP_RD:  decide_end = (fill_ff == '0);
         idt_pkg::BK_POP_CHK: decide_end = !pop_more;
         idt_pkg::BK_DRN_RD:  rd_addr = drain_idx[ADDR_W-1:0];
         idt_pkg::BK_DRN_EMIT: begin
            rd_addr = drain_idx[ADDR_W-1:0];
            gen_req = 1'b1;
         end
         idt_pkg::BK_FLUSH: flush_fire = hold_valid_ff && out_free;
         idt_pkg::BK_CMD,
         idt_pkg::BK_TOP_RD: q_pop = 1'b0;
         default:            q_pop = 1'b0;
      endcase
   end

   assign gen_fire = gen_req && gen_ok && !cap_hit;
   assign wr_en    = (state_ff == idt_pkg::BK_TOP_CHK) && w_gt_top && !full && gen_ok;
   assign wr_addr  = fill_ff[ADDR_W-1:0];
   assign load_out = (gen_fire && hold_valid_ff) || flush_fire;

   // stack and per-word bookkeeping
   always_comb begin
      cmd_kind_in = cmd_kind_ff;
      cmd_w_in    = cmd_w_ff;
      fill_in     = fill_ff;
      pend_in     = pend_ff;
      post_in     = post_ff;
      res_cnt_in  = res_cnt_ff;
      if (q_pop) begin
         cmd_kind_in = q_kind;
         cmd_w_in    = q_data[WIDTH_BITS-1:0];
         post_in     = 1'b0;
         res_cnt_in  = '0;
      end
      if (state_ff == idt_pkg::BK_CMD) begin
         if (cmd_kind_ff == idt_pkg::CMD_EOI) begin
            // close every open level, top first
            pend_in = fill_ff + pend_ff;
            fill_in = '0;
            post_in = 1'b1;
         end else if (cmd_kind_ff != idt_pkg::CMD_NOP) begin
            // a new line drops dedents left over from the last word
            pend_in = '0;
         end
      end
      if (wr_en) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      if ((state_ff == idt_pkg::BK_TOP_CHK && w_lt_top)
          || (state_ff == idt_pkg::BK_POP_CHK && pop_more)) begin
         fill_in = fill_ff - FILL_W'(1);
         pend_in = pend_ff + FILL_W'(1);
      end
      if (state_ff == idt_pkg::BK_DRN_EMIT && gen_ok) begin
         pend_in = pend_ff - FILL_W'(1);
      end
      if (decide_end) begin
         if (cmd_kind_ff == idt_pkg::CMD_EOI_DECIDE) begin
            cmd_kind_in = idt_pkg::CMD_EOI;
         end else begin
            post_in = 1'b1;
         end
      end
      if (gen_fire) begin
         res_cnt_in = res_cnt_ff + CNT_W'(1);
      end
   end

   // staging and output register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_w_in     = hold_w_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hold_kind_ff;
         rsp_w_in     = hold_w_ff;
         rsp_last_in  = flush_fire;
      end
      if (gen_fire) begin
         hold_valid_in = 1'b1;
         hold_kind_in  = gen_kind;
         hold_w_in     = gen_w;
      end else if (flush_fire) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= idt_pkg::BK_IDLE;
         cmd_kind_ff   <= idt_pkg::CMD_NOP;
         fill_ff       <= '0;
         pend_ff       <= '0;
         post_ff       <= 1'b0;
         res_cnt_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmd_kind_ff   <= cmd_kind_in;
         fill_ff       <= fill_in;
         pend_ff       <= pend_in;
         post_ff       <= post_in;
         res_cnt_ff    <= res_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_w_ff    <= cmd_w_in;
      hold_kind_ff <= hold_kind_in;
      hold_w_ff   <= hold_w_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_last_ff <= rsp_last_in;
   end

   // level stack
   idt_ram #(
      .WIDTH (WIDTH_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_w_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_w_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // open plus unreported levels never exceed the stack
   `IDT_ASSERT_ALWAYS(a_stack_bound, clock, reset, used <= USED_MAX, "stack accounting overrun")
   // tokens per word stay within the limit
   `IDT_ASSERT_ALWAYS(a_res_cap, clock, reset, res_cnt_ff <= CNT_MAX, "token count overrun")
   // a word is finished only after its staged token has left
   `IDT_ASSERT_IMPLY(a_idle_no_hold, clock, reset, state_ff == idt_pkg::BK_IDLE, !hold_valid_ff, "staged token left behind")

endmodule

>>> rtl/core/indent_dedent_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_dedent_tokenizer
// Offside-rule tokenizer: reads text bytes and emits INDENT / DEDENT tokens.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata char_code, tlast end_of_input
//   rsp      out  rsp_tvalid/rsp_tready  tdata level_width, tuser token_kind,
//                                        tlast last token of an input word
//   csr      in   csr_we                 csr_index, csr_wdata (no read-back)
//
// The line scanner takes one byte per cycle while the four-entry command
// queue has room. The level engine pops a byte that decides nothing while
// idle; a line start decision reads the stack top, then pops levels and
// emits dedent tokens one by one, paced by the single stack RAM read port.
// Reset is synchronous and clears the stack and the line state.
// Either side may stall on its own; the queue and the output register
// decouple them.
// ----------------------------------------------------------------------------
module indent_dedent_tokenizer #(
   parameter int STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF,
   parameter int WIDTH_BITS  = idt_pkg::WIDTH_BITS_DEF,
   parameter int QUEUE_DEPTH = idt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // input bytes
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [idt_pkg::CHAR_W-1:0]   req_tdata,   // [7:0] char_code
   input  logic                         req_tlast,   // end_of_input
   // tokens
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [idt_pkg::LEVEL_W-1:0]  rsp_tdata,   // [15:0] level_width
   output logic [1:0]                   rsp_tuser,   // [1:0] token_kind
   output logic                         rsp_tlast,   // last
   // configuration
   input  logic                         csr_we,
   input  logic [0:0]                   csr_index,
   input  logic [idt_pkg::TAB_W-1:0]    csr_wdata
);

   localparam int CMD_W = idt_pkg::CMD_KIND_W + WIDTH_BITS;

   logic             push_valid, push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [CMD_W-1:0] pop_data;

   // line scanner
   idt_front #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_ready    (push_ready),
      .q_push     (push_valid),
      .q_data     (push_data)
   );

   // command queue
   idt_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // level engine
   idt_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .WIDTH_BITS  (WIDTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_data     (pop_data),
      .q_pop      (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/tb_indent_dedent_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indent_dedent_tokenizer
// Self-checking bench for the offside-rule tokenizer. Text bytes are streamed
// in as directed lines, a nesting run with a long output hold-off and random
// lines with comment, slash, blank and noise content. A behavioral line
// tracker inside the scoreboard predicts every INDENT, DEDENT and overflow
// token, which is compared in order with the tokens that come out.
// ----------------------------------------------------------------------------
module tb_indent_dedent_tokenizer;
   import idt_pkg::*;

   localparam int          DEPTH           = STACK_DEPTH_DEF;
   localparam int unsigned WIDTH_MAX       = (1 << WIDTH_BITS_DEF) - 1;
   localparam int          QUIET_LIMIT     = 5000;
   localparam int          SETTLE_CYCLES   = 200;
   localparam int          HOLD_CYCLES     = 400;
   localparam int          WORDS_PER_PHASE = 30;
   localparam int          NEST_LINES      = 12;
   localparam int          MAX_REPORTS     = 10;

   typedef struct packed {
      tok_type   kind;
      level_type width;
      logic      last;
   } tok_rec;

   // scoreboard: line tracker plus queue of expected tokens
   class token_board;
      level_type   levels [DEPTH];
      int unsigned fill, pend, lead, tab;
      bit          in_body, slash, skip;
      tok_rec      want [$];
      tok_rec      fresh [$];
      int          errors, words;

      function new();
         fill    = 0;
         pend    = 0;
         tab     = TAB_WIDTH_RST;
         skip    = SKIP_CMT_RST;
         errors  = 0;
         words   = 0;
         start_line();
      endfunction

      function void start_line();
         in_body = 1'b0;
         lead    = 0;
         slash   = 1'b0;
      endfunction

      function void set_reg(csr_type idx, int unsigned v);
         if (idx == CSR_TAB_WIDTH) begin
            tab = v & 32'h7F;
         end else begin
            skip = v[0];
         end
      endfunction

      function bit is_eol(logic [7:0] ch);
         return ch == CH_LF || ch == CH_CR;
      endfunction

      // tokens beyond the per-word limit are dropped
      function void add_token(tok_type k, int unsigned w);
         tok_rec t;
         if (fresh.size() >= MAX_RESULTS) return;
         t.kind  = k;
         t.width = level_type'(w);
         t.last  = 1'b0;
         fresh.push_back(t);
      endfunction

      // popped levels still sit just above the fill mark
      function void report_pops();
         int unsigned idx;
         while (pend > 0 && fresh.size() < MAX_RESULTS) begin
            idx = fill + pend - 1;
            add_token(TOK_DEDENT, idx < DEPTH ? levels[idx] : 0);
            pend--;
         end
      endfunction

      // first significant byte of a line: compare with the top level
      function void settle_line();
         int unsigned top;
         pend = 0;
         top  = (fill > 0 && fill <= DEPTH) ? levels[fill-1] : 0;
         if (lead > top) begin
            if (fill >= DEPTH) begin
               add_token(TOK_OVERFLOW, lead);
            end else begin
               levels[fill] = level_type'(lead);
               fill++;
               add_token(TOK_INDENT, lead);
            end
         end else if (lead < top) begin
            while (fill > 0 && fill <= DEPTH && levels[fill-1] > lead) begin
               fill--;
               pend++;
            end
            report_pops();
         end
      endfunction

      function void note_word(logic [7:0] ch, logic eoi);
         longint unsigned sum;
         tok_rec          t;
         fresh.delete();
         words++;
         report_pops();
         if (eoi) begin
            if (!in_body && slash) settle_line();
            if (fill > DEPTH) fill = DEPTH;
            pend += fill;
            fill = 0;
            report_pops();
            start_line();
         end else if (in_body) begin
            if (is_eol(ch)) start_line();
         end else if (slash) begin
            if (ch == CH_SLASH) begin
               slash   = 1'b0;
               in_body = 1'b1;
            end else begin
               settle_line();
               if (is_eol(ch)) begin
                  start_line();
               end else begin
                  slash   = 1'b0;
                  in_body = 1'b1;
               end
            end
         end else if (ch == CH_SPACE || ch == CH_TAB) begin
            sum  = lead + ((ch == CH_SPACE) ? 1 : tab);
            lead = (sum > WIDTH_MAX) ? WIDTH_MAX : int'(sum);
         end else if (is_eol(ch)) begin
            start_line();
         end else if (ch == CH_SLASH && skip) begin
            slash = 1'b1;
         end else begin
            settle_line();
            in_body = 1'b1;
         end
         // mark the final token of this word
         if (fresh.size() > 0) begin
            t = fresh.pop_back();
            t.last = 1'b1;
            fresh.push_back(t);
         end
         foreach (fresh[i]) want.push_back(fresh[i]);
      endfunction

      function void check(logic [1:0] kind, level_type width, logic last);
         tok_rec exp;
         if (want.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected token: kind %0d width %0d last %0d", kind, width, last);
            return;
         end
         exp = want.pop_front();
         if (exp.kind != tok_type'(kind) || exp.width != width || exp.last != last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("token mismatch: expected kind %0d width %0d last %0d, got %0d %0d %0d",
                        exp.kind, exp.width, exp.last, kind, width, last);
         end
      endfunction

      function int pending();
         return want.size();
      endfunction
   endclass

   // dut signals
   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [LEVEL_W-1:0]   rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   csr_type              csr_index  = CSR_TAB_WIDTH;
   logic [TAB_W-1:0]     csr_wdata  = '0;

   token_board sb = new();
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   logic       hold_off       = 1'b0;
   int         quiet          = 0;
   int         prev_w         = 0;

   indent_dedent_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_code
      .req_tlast  (req_tlast),   // end_of_input
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] level_width
      .rsp_tuser  (rsp_tuser),   // [1:0] token_kind
      .rsp_tlast  (rsp_tlast),   // last
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // output back-pressure
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // token check and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tuser, rsp_tdata, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet <= 0;
         end else begin
            quiet <= quiet + 1;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one input word, with optional idle gap in front
   task automatic send_word(input logic [7:0] ch, input logic eoi);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
      sb.note_word(ch, eoi);
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   task automatic set_idle(input int s, input int r);
      send_idle_pct = s;
      recv_stall_pct <= r;
   endtask

   // drain all tokens and let a silent decision finish
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_type idx, input int unsigned v);
      quiesce();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[TAB_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   // leading whitespace of a given width, tabs and spaces mixed
   task automatic send_lead(input int w);
      int t, s;
      if (sb.tab > 0 && $urandom_range(1)) begin
         t = w / sb.tab;
         s = w % sb.tab;
      end else begin
         t = 0;
         s = w;
      end
      if (sb.tab == 0) t = $urandom_range(2);
      while (t + s > 0) begin
         if (t > 0 && (s == 0 || $urandom_range(1))) begin
            send_word(CH_TAB, 1'b0);
            t--;
         end else begin
            send_word(CH_SPACE, 1'b0);
            s--;
         end
      end
   endtask

   // significant first byte, then any bytes
   task automatic send_body();
      send_word(8'($urandom_range(8'h41, 8'h7A)), 1'b0);
      repeat ($urandom_range(4)) send_word(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_eol();
      case ($urandom_range(2))
         0: send_word(CH_LF, 1'b0);
         1: send_word(CH_CR, 1'b0);
         default: begin
            send_word(CH_CR, 1'b0);
            send_word(CH_LF, 1'b0);
         end
      endcase
   endtask

   // mostly code lines walking the nesting up and down, plus odd lines
   task automatic random_words(input int count);
      int stop, r, w;
      stop = sb.words + count;
      while (sb.words < stop) begin
         r = $urandom_range(99);
         if (r < 50) begin
            case ($urandom_range(2))
               0: w = prev_w;
               1: w = prev_w + $urandom_range(1, 6);
               default: w = $urandom_range(prev_w);
            endcase
            if (w > 60) w = $urandom_range(8);
            prev_w = w;
            send_lead(w);
            send_body();
            send_eol();
         end else if (r < 60) begin
            send_lead($urandom_range(12));
            send_word(CH_SLASH, 1'b0);
            send_word(CH_SLASH, 1'b0);
            send_body();
            send_eol();
         end else if (r < 68) begin
            send_lead($urandom_range(12));
            send_word(CH_SLASH, 1'b0);
            if ($urandom_range(1)) send_body();
            send_eol();
         end else if (r < 78) begin
            send_lead($urandom_range(6));
            send_eol();
         end else if (r < 90) begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(255)), 1'b0);
         end else begin
            send_word(8'($urandom_range(255)), 1'b1);
            if ($urandom_range(3) == 0) send_word(8'($urandom_range(255)), 1'b1);
            prev_w = 0;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed lines at reset settings
      send_str("  x\n");
      send_str("\ty\r\n");
      send_str(" \n");
      send_str(" //z\n");
      send_str("   /q\n");
      send_str("/");
      send_word("Z", 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(CH_SPACE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(CH_LF, 1'b0);

      // narrow tabs, slashes as plain bytes
      write_reg(CSR_TAB_WIDTH, 1);
      write_reg(CSR_SKIP_COMMENT, 0);
      random_words(WORDS_PER_PHASE);

      // wide tabs, slow sender
      write_reg(CSR_TAB_WIDTH, 64);
      write_reg(CSR_SKIP_COMMENT, 1);
      set_idle(77, 0);
      random_words(WORDS_PER_PHASE);

      // nested lines while the output is held off
      quiesce();
      set_idle(0, 0);
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      for (int k = 1; k <= NEST_LINES; k++) begin
         repeat (k / 4) send_word(CH_TAB, 1'b0);
         repeat (k % 4) send_word(CH_SPACE, 1'b0);
         send_str("x\n");
      end
      send_word(8'h5A, 1'b1);
      prev_w = 0;

      // tabs that count nothing, stalling receiver
      write_reg(CSR_TAB_WIDTH, 0);
      set_idle(0, 77);
      random_words(WORDS_PER_PHASE);

      // both sides idling
      write_reg(CSR_TAB_WIDTH, 4);
      write_reg(CSR_SKIP_COMMENT, 0);
      set_idle(19, 19);
      random_words(WORDS_PER_PHASE);

      quiesce();
      sb.errors += sb.pending();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
